/* design/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
// No dependencies; the front, queue, back and top design files import this package.
package jsu_pkg;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_STRING = 2'd1,
		MODE_ESCAPE = 2'd2,
		MODE_HEX    = 2'd3
	} parse_mode_t;

	localparam logic [7:0] CHAR_QUOTE     = 8'h22;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
	localparam logic [7:0] CHAR_SLASH     = 8'h2f;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
	localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
	localparam logic [7:0] CHAR_LOWER_N   = 8'h6e;
	localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
	localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
	localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
	localparam logic [7:0] CTRL_BS        = 8'h08;
	localparam logic [7:0] CTRL_FF        = 8'h0c;
	localparam logic [7:0] CTRL_LF        = 8'h0a;
	localparam logic [7:0] CTRL_CR        = 8'h0d;
	localparam logic [7:0] CTRL_TAB       = 8'h09;

	localparam logic [15:0] UTF8_ONE_MAX = 16'h007f;
	localparam logic [15:0] UTF8_TWO_MAX = 16'h07ff;

	// One queue entry: all results caused by one input byte. Data bytes go
	// out first (data[0] first), then the optional done or error result.
	typedef struct packed {
		logic [1:0]       n_data;
		logic [2:0][7:0]  data;
		logic             has_tail;
		result_kind_t     tail_kind;
	} jsu_entry_t;

endpackage

/* design/jsu_if.sv */
// Valid/ready stream interfaces for the input text and the result channel.
// No dependencies.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_buffer;

	modport source (output valid, output in_byte, output end_of_buffer, input ready);
	modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output result_kind, output out_byte, output run_last,
		input ready);
	modport sink (input valid, input result_kind, input out_byte, input run_last,
		output ready);
endinterface

/* design/jsu_front.sv */
// Front end: accepts text bytes, runs the parse state machine and builds
// one queue entry per byte that causes results. Depends on jsu_pkg, jsu_if.
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	jsu_in_if.sink            text,
	input  logic              q_full,
	output logic              push,
	output jsu_pkg::jsu_entry_t push_entry
);
	import jsu_pkg::*;

	parse_mode_t mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] accum_q, accum_d;

	logic [7:0]  c;
	logic        eob;
	logic        eob_eff;
	logic        failed;
	logic        err;
	logic        done;
	logic        is_space;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] acc_new;
	logic [1:0]  n_data;
	logic [2:0][7:0] data;
	logic        accept;

	assign c = text.in_byte;
	assign eob = text.end_of_buffer;
	assign text.ready = !q_full;
	assign accept = text.valid && text.ready;

	assign is_space = (c == CHAR_SPACE) || (c >= CTRL_TAB && c <= CTRL_CR);

	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hex_val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			hex_val = 4'(c - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_new = {accum_q[11:0], hex_val};

	always_comb begin
		mode_d = mode_q;
		hex_cnt_d = hex_cnt_q;
		accum_d = accum_q;
		failed = 1'b0;
		done = 1'b0;
		eob_eff = eob;
		n_data = 2'd0;
		data = '0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (is_space) begin
					failed = eob;
				end else if (c == CHAR_QUOTE) begin
					mode_d = MODE_STRING;
					failed = eob;
				end else begin
					failed = 1'b1;
				end
			end
			MODE_STRING: begin
				if (c == CHAR_QUOTE) begin
					done = 1'b1;
					mode_d = MODE_IDLE;
					eob_eff = 1'b0;
				end else if (c < CHAR_SPACE) begin
					failed = 1'b1;
				end else if (c == CHAR_BACKSLASH) begin
					mode_d = MODE_ESCAPE;
				end else begin
					n_data = 2'd1;
					data[0] = c;
				end
			end
			MODE_ESCAPE: begin
				mode_d = MODE_STRING;
				n_data = 2'd1;
				unique case (c)
					CHAR_QUOTE:     data[0] = CHAR_QUOTE;
					CHAR_BACKSLASH: data[0] = CHAR_BACKSLASH;
					CHAR_SLASH:     data[0] = CHAR_SLASH;
					CHAR_LOWER_B:   data[0] = CTRL_BS;
					CHAR_LOWER_F:   data[0] = CTRL_FF;
					CHAR_LOWER_N:   data[0] = CTRL_LF;
					CHAR_LOWER_R:   data[0] = CTRL_CR;
					CHAR_LOWER_T:   data[0] = CTRL_TAB;
					CHAR_LOWER_U: begin
						n_data = 2'd0;
						mode_d = MODE_HEX;
						hex_cnt_d = 2'd0;
						accum_d = '0;
					end
					default: begin
						n_data = 2'd0;
						mode_d = MODE_ESCAPE;
						failed = 1'b1;
					end
				endcase
			end
			MODE_HEX: begin
				if (!hex_ok) begin
					failed = 1'b1;
				end else if (hex_cnt_q == 2'd3) begin
					if (acc_new <= UTF8_ONE_MAX) begin
						n_data = 2'd1;
						data[0] = acc_new[7:0];
					end else if (acc_new <= UTF8_TWO_MAX) begin
						n_data = 2'd2;
						data[0] = {3'b110, acc_new[10:6]};
						data[1] = {2'b10, acc_new[5:0]};
					end else begin
						n_data = 2'd3;
						data[0] = {4'b1110, acc_new[15:12]};
						data[1] = {2'b10, acc_new[11:6]};
						data[2] = {2'b10, acc_new[5:0]};
					end
					mode_d = MODE_STRING;
					hex_cnt_d = 2'd0;
					accum_d = '0;
				end else begin
					hex_cnt_d = hex_cnt_q + 2'd1;
					accum_d = acc_new;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		err = failed || (eob_eff && (mode_d != MODE_IDLE));
		if (err) begin
			mode_d = MODE_IDLE;
			hex_cnt_d = 2'd0;
			accum_d = '0;
		end
	end

	assign push = accept && ((n_data != 2'd0) || done || err);

	always_comb begin
		push_entry.n_data = n_data;
		push_entry.data = data;
		push_entry.has_tail = done || err;
		push_entry.tail_kind = err ? KIND_ERROR : KIND_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_cnt_q <= 2'd0;
			accum_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			accum_q <= accum_d;
		end
	end

endmodule

/* design/jsu_queue.sv */
// Small FIFO of result entries between the front and back ends.
// Depends on jsu_pkg.
module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jsu_pkg::jsu_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output jsu_pkg::jsu_entry_t pop_entry,
	output logic                nonempty
);
	import jsu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_entry_t      entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;
	assign pop_entry = entries_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/jsu_back.sv */
// Back end: takes queue entries and sends their results one per cycle, while
// the result channel takes them, through a registered output stage. Depends on jsu_pkg, jsu_if.
module jsu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_nonempty,
	input  jsu_pkg::jsu_entry_t q_entry,
	output logic                pop,
	jsu_out_if.source           result
);
	import jsu_pkg::*;

	jsu_entry_t   cur_q;
	logic         cur_valid_q;
	logic [1:0]   pos_q;
	logic         out_valid_q;
	result_kind_t kind_q;
	logic [7:0]   byte_q;
	logic         last_q;

	logic [2:0]   total;
	logic         emit;
	logic         emit_last;
	logic         is_data;
	logic [7:0]   sel_byte;

	assign total = {1'b0, cur_q.n_data} + {2'b00, cur_q.has_tail};
	assign emit = cur_valid_q && (!out_valid_q || result.ready);
	assign emit_last = ({1'b0, pos_q} + 3'd1) == total;
	assign is_data = pos_q < cur_q.n_data;
	assign pop = q_nonempty && (!cur_valid_q || (emit && emit_last));

	always_comb begin
		case (pos_q)
			2'd0: sel_byte = cur_q.data[0];
			2'd1: sel_byte = cur_q.data[1];
			2'd2: sel_byte = cur_q.data[2];
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				pos_q <= 2'd0;
			end else if (emit && emit_last) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_entry;
		end
		if (emit) begin
			kind_q <= is_data ? KIND_DATA : cur_q.tail_kind;
			byte_q <= is_data ? sel_byte : 8'd0;
			last_q <= emit_last;
		end
	end

	assign result.valid = out_valid_q;
	assign result.result_kind = kind_q;
	assign result.out_byte = byte_q;
	assign result.run_last = last_q;

endmodule

/* design/json_string_unescaper_core.sv */
// Top level of the streaming JSON string unescaper.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
//
// The block takes one text byte per transaction on the text channel and
// returns decoded results on the result channel. Before a string it skips
// whitespace and waits for an opening double quote; inside the string it
// copies plain bytes, decodes the short backslash escapes and turns a \u
// escape with four hex digits into one to three UTF-8 bytes (surrogate
// pairs are passed through as separate code units). A closing quote gives
// a done result, and malformed input or a buffer that ends inside a string
// gives an error result, after which the block waits for the next string.
// Each text byte causes zero to four results; run_last marks the final
// result of each byte that causes any. The front end accepts one byte
// every cycle and decodes it in the same cycle into an entry of a small
// queue (QUEUE_DEPTH entries). The back end drains that queue through a
// registered output stage at one result per cycle when the result channel
// is ready, so a text byte enters every cycle as long as the queue has
// room; the sustained rate is set by the result channel, which moves one
// result per cycle, and a byte that decodes to several results holds the
// back end until all of them are sent.
module json_string_unescaper_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	jsu_in_if.sink     text,
	jsu_out_if.source  result
);
	import jsu_pkg::*;

	// Entry handoff between the front end and the queue, and from the
	// queue to the back end.
	logic       q_push;
	jsu_entry_t q_push_entry;
	logic       q_full;
	logic       q_pop;
	jsu_entry_t q_pop_entry;
	logic       q_nonempty;

	// The front end owns the parse state and decides, for each byte, all
	// the results it causes in the same cycle that it accepts the byte.
	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	// The queue decouples the two sides so a stalled result channel does
	// not stop text bytes until the queue fills.
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_pop_entry),
		.nonempty   (q_nonempty)
	);

	// The back end serializes each entry into single result transactions.
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_entry    (q_pop_entry),
		.pop        (q_pop),
		.result     (result)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for json_string_unescaper_core: streams JSON strings, noise and broken text
// through the text channel and checks every decoded result against an in-bench predictor.
// Depends on jsu_pkg, the jsu_in_if / jsu_out_if interfaces and the design sources.
module tb_top;
	import jsu_pkg::*;

	localparam int TEXT_ITEMS   = 430;  // rough size of the whole byte stream
	localparam int CALM_TAIL    = 60;   // last bytes are sent with no idling on either side
	localparam int HOLD_CYCLES  = 120;  // length of the long result-side hold-off
	localparam int IDLE_LIMIT   = 2000; // cycles without any transaction before giving up
	localparam int DRAIN_CYCLES = 20;   // settling time after the last expected result

	// One expected or observed result transaction.
	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   data;
		logic         last;
	} decoded_t;

	// Predicts the unescaper byte by byte and holds the results still owed by the block.
	class unescape_scoreboard;
		parse_mode_t mode;
		logic [1:0]  digits_taken;
		logic [15:0] code_unit;
		decoded_t    owed_q[$];
		int          mismatches;

		function new();
			go_idle();
			mismatches = 0;
		endfunction

		function void go_idle();
			mode = MODE_IDLE;
			digits_taken = '0;
			code_unit = '0;
		endfunction

		function decoded_t mk(result_kind_t kind, logic [7:0] data);
			decoded_t r;
			r.kind = kind;
			r.data = (kind == KIND_DATA) ? data : 8'h00;
			r.last = 1'b0;
			return r;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CHAR_SPACE || (c >= CTRL_TAB && c <= CTRL_CR);
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
			return -1;
		endfunction

		// Advances the predicted parser by one accepted text byte and queues what it yields.
		function void note_text(logic [7:0] c, logic eob);
			decoded_t    step_out [4];
			int          n;
			int          nib;
			bit          failed;
			bit          end_seen;
			logic [15:0] v;
			n = 0;
			failed = 1'b0;
			end_seen = eob;
			case (mode)
				MODE_IDLE: begin
					if (is_blank(c)) begin
						failed = eob;
					end else if (c == CHAR_QUOTE) begin
						mode = MODE_STRING;
						failed = eob;
					end else begin
						failed = 1'b1;
					end
				end
				MODE_STRING: begin
					if (c == CHAR_QUOTE) begin
						// The closing quote wins over end of buffer.
						step_out[n] = mk(KIND_DONE, 8'h00);
						n++;
						go_idle();
						end_seen = 1'b0;
					end else if (c < CHAR_SPACE) begin
						failed = 1'b1;
					end else if (c == CHAR_BACKSLASH) begin
						mode = MODE_ESCAPE;
					end else begin
						step_out[n] = mk(KIND_DATA, c);
						n++;
					end
				end
				MODE_ESCAPE: begin
					mode = MODE_STRING;
					case (c)
						CHAR_QUOTE:     step_out[n] = mk(KIND_DATA, CHAR_QUOTE);
						CHAR_BACKSLASH: step_out[n] = mk(KIND_DATA, CHAR_BACKSLASH);
						CHAR_SLASH:     step_out[n] = mk(KIND_DATA, CHAR_SLASH);
						CHAR_LOWER_B:   step_out[n] = mk(KIND_DATA, CTRL_BS);
						CHAR_LOWER_F:   step_out[n] = mk(KIND_DATA, CTRL_FF);
						CHAR_LOWER_N:   step_out[n] = mk(KIND_DATA, CTRL_LF);
						CHAR_LOWER_R:   step_out[n] = mk(KIND_DATA, CTRL_CR);
						CHAR_LOWER_T:   step_out[n] = mk(KIND_DATA, CTRL_TAB);
						CHAR_LOWER_U: begin
							mode = MODE_HEX;
							digits_taken = '0;
							code_unit = '0;
						end
						default: failed = 1'b1;
					endcase
					if (mode == MODE_STRING && !failed) n++;
				end
				default: begin
					nib = hex_nibble(c);
					if (nib < 0) begin
						failed = 1'b1;
					end else begin
						code_unit = {code_unit[11:0], nib[3:0]};
						if (digits_taken == 2'd3) begin
							v = code_unit;
							if (v <= UTF8_ONE_MAX) begin
								step_out[n] = mk(KIND_DATA, v[7:0]);
								n++;
							end else if (v <= UTF8_TWO_MAX) begin
								step_out[n] = mk(KIND_DATA, {3'b110, v[10:6]});
								step_out[n + 1] = mk(KIND_DATA, {2'b10, v[5:0]});
								n += 2;
							end else begin
								step_out[n] = mk(KIND_DATA, {4'b1110, v[15:12]});
								step_out[n + 1] = mk(KIND_DATA, {2'b10, v[11:6]});
								step_out[n + 2] = mk(KIND_DATA, {2'b10, v[5:0]});
								n += 3;
							end
							mode = MODE_STRING;
							digits_taken = '0;
							code_unit = '0;
						end else begin
							digits_taken = digits_taken + 2'd1;
						end
					end
				end
			endcase
			// An error comes after any data bytes of the same input byte.
			if (failed || (end_seen && mode != MODE_IDLE)) begin
				step_out[n] = mk(KIND_ERROR, 8'h00);
				n++;
				go_idle();
			end
			if (n > 0) step_out[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++) owed_q.insert(owed_q.size(), step_out[i]);
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
			decoded_t want;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual kind=%0d byte=%02h last=%0b",
					$time, kind, data, last);
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			if (kind !== want.kind || data !== want.data || last !== want.last) begin
				$display("%0t: result mismatch: expected kind=%0d byte=%02h last=%0b,",
					$time, want.kind, want.data, want.last);
				$display("%0t:   actual kind=%0d byte=%02h last=%0b",
					$time, kind, data, last);
				mismatches++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	jsu_in_if  text_if ();
	jsu_out_if result_if ();

	json_string_unescaper_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if)
	);

	unescape_scoreboard sb;
	bit sender_idles;   // random gaps before text transactions
	bit calm_tail;      // no idling on either side for the last part of the run
	bit hold_request;   // asks the result side for one long hold-off
	int text_sent;
	int idle_cycles;

	always #5 clk = ~clk;

	// Result monitor. Sampling at the edge sees the values the block saw, since all
	// registered outputs update in the nonblocking region.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.result_kind, result_if.out_byte, result_if.run_last);
	end

	// Watchdog: a run that stops moving on both channels for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (text_if.valid && text_if.ready) || (result_if.valid && result_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Result side: random bursts of stalled cycles, plus one long hold-off
	// on request so that the block's queue fills and it backs up the text channel.
	initial begin : result_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
				result_if.ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Offers one text byte and returns at the edge where it is accepted. Valid is left
	// high so that back-to-back bytes never see a low and a high in the same step.
	task automatic send_text(input logic [7:0] c, input logic eob);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			text_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.in_byte <= c;
		text_if.end_of_buffer <= eob;
		@(posedge clk);
		while (!text_if.ready) @(posedge clk);
		sb.note_text(c, eob);
		text_sent++;
	endtask

	// Stops sending and waits until the block has returned everything it owes.
	task automatic pause_for_results();
		text_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return CHAR_SPACE;
			1: return CTRL_TAB;
			2: return CTRL_LF;
			3: return 8'h0b;
			4: return CTRL_FF;
			default: return CTRL_CR;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] h);
		if (h < 4'd10) return 8'h30 + h;
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + (h - 4'd10);
	endfunction

	function automatic logic [7:0] pick_escape_name();
		case ($urandom_range(0, 7))
			0: return CHAR_QUOTE;
			1: return CHAR_BACKSLASH;
			2: return CHAR_SLASH;
			3: return CHAR_LOWER_B;
			4: return CHAR_LOWER_F;
			5: return CHAR_LOWER_N;
			6: return CHAR_LOWER_R;
			default: return CHAR_LOWER_T;
		endcase
	endfunction

	// Builds one string with random content, often well formed, sometimes damaged,
	// and sends it byte by byte.
	task automatic send_json_string();
		logic [7:0]  chars[$];
		logic [7:0]  c;
		logic [15:0] cp;
		logic        eob_last;
		int          pos;
		repeat ($urandom_range(0, 2)) chars = {chars, pick_blank()};
		chars = {chars, CHAR_QUOTE};
		repeat ($urandom_range(0, 8)) begin
			case ($urandom_range(0, 9))
				5, 6: begin
					chars = {chars, CHAR_BACKSLASH, pick_escape_name()};
				end
				7, 8, 9: begin
					// Spread code units over the one, two and three byte encodings.
					case ($urandom_range(0, 2))
						0: cp = 16'($urandom_range(0, 'h7f));
						1: cp = 16'($urandom_range('h80, 'h7ff));
						default: cp = 16'($urandom_range('h800, 'hffff));
					endcase
					chars = {chars, CHAR_BACKSLASH, CHAR_LOWER_U};
					chars = {chars, hex_char(cp[15:12]), hex_char(cp[11:8])};
					chars = {chars, hex_char(cp[7:4]), hex_char(cp[3:0])};
				end
				default: begin
					do begin
						c = 8'($urandom_range('h20, 'hff));
					end while (c == CHAR_QUOTE || c == CHAR_BACKSLASH);
					chars = {chars, c};
				end
			endcase
		end
		chars = {chars, CHAR_QUOTE};
		eob_last = ($urandom_range(0, 2) == 0);
		case ($urandom_range(0, 7))
			0: begin
				// Overwrite one byte with anything at all.
				pos = $urandom_range(0, chars.size() - 1);
				chars[pos] = 8'($urandom_range(0, 255));
			end
			1: begin
				// The buffer ends before the string does.
				repeat ($urandom_range(1, chars.size() - 1)) void'(chars.pop_back());
				eob_last = 1'b1;
			end
			2: begin
				// A raw control byte somewhere after the first byte.
				pos = $urandom_range(chars.size() - 1, 1);
				chars.insert(pos, 8'($urandom_range(0, 'h1f)));
			end
			default: ;
		endcase
		for (int i = 0; i < chars.size(); i++)
			send_text(chars[i], eob_last && i == chars.size() - 1);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 3))
			send_text(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	// Long plain string offered back to back while the result side holds off.
	task automatic send_during_hold();
		bit saved;
		saved = sender_idles;
		sender_idles = 1'b0;
		hold_request = 1'b1;
		send_text(CHAR_QUOTE, 1'b0);
		for (int i = 0; i < 40; i++) send_text(8'h61 + i[4:0], 1'b0);
		send_text(CHAR_QUOTE, 1'b0);
		sender_idles = saved;
	endtask

	initial begin : stimulus
		bit hold_done;
		bit pause_done;
		sb = new();
		hold_done = 1'b0;
		pause_done = 1'b0;
		sender_idles = 1'b1;
		calm_tail = 1'b0;
		hold_request = 1'b0;
		text_sent = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		text_if.valid <= 1'b0;
		text_if.in_byte <= 8'h00;
		text_if.end_of_buffer <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A stray byte before any string, then whitespace and a quote
		// that each carry end of buffer.
		send_text(8'h78, 1'b0);
		send_text(CHAR_SPACE, 1'b1);
		send_text(CHAR_QUOTE, 1'b1);
		// Open a string and hit it with the lowest control byte.
		send_text(CTRL_TAB, 1'b0);
		send_text(CHAR_QUOTE, 1'b0);
		send_text(8'h00, 1'b0);
		// Top plain byte, a short escape, then an escape letter that means nothing.
		send_text(CHAR_QUOTE, 1'b0);
		send_text(8'hff, 1'b0);
		send_text(CHAR_BACKSLASH, 1'b0);
		send_text(CHAR_LOWER_N, 1'b0);
		send_text(CHAR_BACKSLASH, 1'b0);
		send_text(8'h71, 1'b0);
		// Largest code unit in mixed case; its last digit ends the buffer, which gives
		// three data bytes and an error from one text byte.
		send_text(CHAR_QUOTE, 1'b0);
		send_text(CHAR_BACKSLASH, 1'b0);
		send_text(CHAR_LOWER_U, 1'b0);
		send_text(8'h46, 1'b0);
		send_text(8'h66, 1'b0);
		send_text(8'h46, 1'b0);
		send_text(8'h66, 1'b1);
		// A non-hex byte inside a unicode escape.
		send_text(CHAR_QUOTE, 1'b0);
		send_text(CHAR_BACKSLASH, 1'b0);
		send_text(CHAR_LOWER_U, 1'b0);
		send_text(8'h30, 1'b0);
		send_text(8'h67, 1'b0);
		// A closing quote that also ends the buffer gives only the done result.
		send_text(CHAR_QUOTE, 1'b0);
		send_text(8'h41, 1'b0);
		send_text(CHAR_QUOTE, 1'b1);

		// Random part: mostly strings with random content, some raw noise.
		while (text_sent < TEXT_ITEMS) begin
			if (text_sent >= TEXT_ITEMS - CALM_TAIL) begin
				calm_tail = 1'b1;
				sender_idles = 1'b0;
			end
			if (!hold_done && text_sent >= 150) begin
				send_during_hold();
				hold_done = 1'b1;
			end else if (!pause_done && text_sent >= 300) begin
				pause_for_results();
				pause_done = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				send_noise();
			end else begin
				send_json_string();
			end
		end

		pause_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0t: %0d mismatches, %0d results never arrived",
				$time, sb.mismatches, sb.pending());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/jsu_pkg.sv
design/jsu_if.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescaper_core.sv
tb/tb_top.sv
